// ===== rtl/gcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, field widths and denomination tables of the change dispenser.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // item field widths
  localparam int CMD_W     = 2;
  localparam int CODE_W    = 3;
  localparam int AMT_W     = 16;
  localparam int GIVEN_W   = 8;
  localparam int STAT_W    = 2;
  localparam int MAX_COINS = 8;

  // denomination value width and reciprocal format for the quotient
  localparam int VAL_W       = 10;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_MAKE   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_EXACT = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_INS,
    S_CHK,
    S_MIN,
    S_SUB,
    S_OUT,
    S_EMIT
  } fsm_e;

  // value of a denomination in cents
  function automatic logic [VAL_W-1:0] denom_value(input logic [CODE_W-1:0] code);
    logic [VAL_W-1:0] v;
    case (code)
      3'd0:    v = 10'd5;
      3'd1:    v = 10'd10;
      3'd2:    v = 10'd20;
      3'd3:    v = 10'd50;
      3'd4:    v = 10'd100;
      3'd5:    v = 10'd200;
      3'd6:    v = 10'd500;
      default: v = 10'd1000;
    endcase
    return v;
  endfunction

  // ceil(2^32 / value): exact floor quotient for any 16-bit amount
  function automatic logic [RECIP_W-1:0] denom_recip(input logic [CODE_W-1:0] code);
    logic [RECIP_W-1:0] r;
    case (code)
      3'd0:    r = 30'd858993460;
      3'd1:    r = 30'd429496730;
      3'd2:    r = 30'd214748365;
      3'd3:    r = 30'd85899346;
      3'd4:    r = 30'd42949673;
      3'd5:    r = 30'd21474837;
      3'd6:    r = 30'd8589935;
      default: r = 30'd4294968;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gcd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_in_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface gcd_in_if
  import gcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CODE_W-1:0] coin_code;
  logic [AMT_W-1:0]  amount_cents;

  modport source (output valid, output command, output coin_code, output amount_cents,
                  input ready);
  modport sink   (input valid, input command, input coin_code, input amount_cents,
                  output ready);
endinterface

// ===== rtl/gcd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_out_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface gcd_out_if
  import gcd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  denom_code;
  logic [GIVEN_W-1:0] coins_given;
  logic               last;
  logic [STAT_W-1:0]  status;
  logic               possible;

  modport source (output valid, output denom_code, output coins_given, output last,
                  output status, output possible, input ready);
  modport sink   (input valid, input denom_code, input coins_given, input last,
                  input status, input possible, output ready);
endinterface

// ===== rtl/gcd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/greedy_change_dispenser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_dispenser_unit
// Coin register with insert, check and greedy make-change commands.
// ----------------------------------------------------------------------------
// The coin counts live in a small RAM with a registered read; reset needs no
// clearing pass, as a per-entry valid bit makes unwritten counts read as zero.
// One command item is handled at a time. Insert reads and then increments the
// count of its coin; check reads and sums the value of every denomination;
// make change runs read / divide-and-limit / debit per denomination on the RAM
// port, then emits one result item per cycle (NUM_COINS items, highest
// denomination first). A result waiting in the output register does not hold
// back the next command item; a stalled result channel stretches the result phase.
// ----------------------------------------------------------------------------
module greedy_change_dispenser_unit
  import gcd_pkg::*;
#(
  parameter int NUM_COINS   = 8,
  parameter int COUNT_WIDTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gcd_in_if.sink     in_i,
  gcd_out_if.source  out_o
);

  localparam int AW     = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
  localparam int CW     = COUNT_WIDTH;
  localparam int WANT_W = AMT_W + RECIP_W - RECIP_SHIFT;
  localparam int MW     = (CW > WANT_W) ? CW : WANT_W;
  localparam int SW     = (CW > GIVEN_W) ? CW : GIVEN_W;
  localparam int PW     = CW + VAL_W;
  localparam int TW     = CW + VAL_W + 3;
  localparam int RP_W   = AMT_W + RECIP_W;

  // control and datapath state
  fsm_e               state_q, state_d;
  cmd_e               cmd_q;
  logic [CODE_W-1:0]  code_q;
  logic [AMT_W-1:0]   amount_q;
  logic [AW-1:0]      idx_q;
  logic [WANT_W-1:0]  want_q;
  logic [CW-1:0]      t_q;
  logic [TW-1:0]      acc_q;
  status_e            ins_status_q;
  logic [GIVEN_W-1:0] taken_q [NUM_COINS];
  logic [NUM_COINS-1:0] valid_q;

  // output register
  logic               out_valid_q;
  logic [CODE_W-1:0]  out_denom_q, out_denom_d;
  logic [GIVEN_W-1:0] out_given_q, out_given_d;
  logic               out_last_q, out_last_d;
  status_e            out_status_q, out_status_d;
  logic               out_possible_q, out_possible_d;
  logic               out_load;
  logic               slot_free;

  // RAM port
  logic               ram_we;
  logic               ram_re;
  logic [CW-1:0]      ram_wdata;
  logic [CW-1:0]      ram_rdata;

  // datapath nets
  logic [CW-1:0]      count_rd;
  logic               count_full;
  logic               last_idx;
  logic               code_ok;
  logic [RP_W-1:0]    recip_prod;
  logic [WANT_W-1:0]  want_d;
  logic [CW-1:0]      t_cnt;
  logic [SW-1:0]      t_ext;
  logic [GIVEN_W-1:0] given_sat;
  logic [PW-1:0]      debit;
  logic [AMT_W-1:0]   amount_sub;
  logic [TW-1:0]      acc_add;
  logic [CODE_W-1:0]  idx_code;

  gcd_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_COINS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // count read back; never-written entries are zero
  assign count_rd   = valid_q[idx_q] ? ram_rdata : '0;
  assign count_full = (count_rd == {CW{1'b1}});
  assign last_idx   = (idx_q == '0);
  assign idx_code   = CODE_W'(idx_q);
  assign code_ok    = (int'(in_i.coin_code) < NUM_COINS);
  assign slot_free  = !out_valid_q || out_o.ready;

  // quotient amount / value by reciprocal multiply
  assign recip_prod = RP_W'(amount_q) * RP_W'(denom_recip(idx_code));
  assign want_d     = recip_prod[RP_W-1:RECIP_SHIFT];

  // coins taken = min(quotient, coins held), saturated for the result
  assign t_cnt     = (MW'(count_rd) < MW'(want_q)) ? count_rd : CW'(want_q);
  assign t_ext     = SW'(t_cnt);
  assign given_sat = (t_ext > SW'(2 ** GIVEN_W - 1)) ? {GIVEN_W{1'b1}} : GIVEN_W'(t_ext);

  // debit the remaining amount
  assign debit      = PW'(t_q) * PW'(denom_value(idx_code));
  assign amount_sub = amount_q - AMT_W'(debit);

  // running total for check
  assign acc_add = acc_q + (TW'(count_rd) * TW'(denom_value(idx_code)));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (cmd_e'(in_i.command))
            CMD_INSERT: state_d = code_ok ? S_READ : S_OUT;
            CMD_CHECK:  state_d = S_READ;
            CMD_MAKE:   state_d = S_READ;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        case (cmd_q)
          CMD_INSERT: state_d = S_INS;
          CMD_CHECK:  state_d = S_CHK;
          default:    state_d = S_MIN;
        endcase
      end
      S_INS:  state_d = S_OUT;
      S_CHK:  state_d = last_idx ? S_OUT : S_READ;
      S_MIN:  state_d = S_SUB;
      S_SUB:  state_d = last_idx ? S_EMIT : S_READ;
      S_OUT:  state_d = slot_free ? S_IDLE : S_OUT;
      S_EMIT: state_d = (slot_free && last_idx) ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs: handshake, RAM port and result payload
  always_comb begin
    in_i.ready     = (state_q == S_IDLE);
    ram_re         = (state_q == S_READ);
    ram_we         = 1'b0;
    ram_wdata      = count_rd - t_cnt;
    out_load       = 1'b0;
    out_denom_d    = '0;
    out_given_d    = '0;
    out_last_d     = 1'b1;
    out_status_d   = STAT_OK;
    out_possible_d = 1'b0;
    case (state_q)
      S_INS: begin
        ram_we    = !count_full;
        ram_wdata = count_rd + 1'b1;
      end
      S_MIN: begin
        ram_we = 1'b1;
      end
      S_OUT: begin
        out_load = slot_free;
        if (cmd_q == CMD_INSERT) begin
          out_denom_d  = code_q;
          out_status_d = ins_status_q;
        end
        out_possible_d = (cmd_q == CMD_CHECK) && (acc_q > TW'(amount_q));
      end
      S_EMIT: begin
        out_load     = slot_free;
        out_denom_d  = idx_code;
        out_given_d  = taken_q[idx_q];
        out_last_d   = last_idx;
        out_status_d = (amount_q != '0) ? STAT_NO_EXACT : STAT_OK;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_q        <= cmd_e'(in_i.command);
          code_q       <= in_i.coin_code;
          amount_q     <= in_i.amount_cents;
          acc_q        <= '0;
          ins_status_q <= STAT_OK;
          idx_q        <= (cmd_e'(in_i.command) == CMD_INSERT) ? AW'(in_i.coin_code)
                                                               : AW'(NUM_COINS - 1);
        end
      end
      S_READ: want_q <= want_d;
      S_INS: begin
        if (count_full) begin
          ins_status_q <= STAT_FULL;
        end
      end
      S_CHK: begin
        acc_q <= acc_add;
        if (!last_idx) begin
          idx_q <= idx_q - 1'b1;
        end
      end
      S_MIN: begin
        t_q            <= t_cnt;
        taken_q[idx_q] <= given_sat;
      end
      S_SUB: begin
        amount_q <= amount_sub;
        idx_q    <= last_idx ? AW'(NUM_COINS - 1) : idx_q - 1'b1;
      end
      S_EMIT: begin
        if (slot_free && !last_idx) begin
          idx_q <= idx_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_denom_q    <= out_denom_d;
      out_given_q    <= out_given_d;
      out_last_q     <= out_last_d;
      out_status_q   <= out_status_d;
      out_possible_q <= out_possible_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.denom_code  = out_denom_q;
  assign out_o.coins_given = out_given_q;
  assign out_o.last        = out_last_q;
  assign out_o.status      = out_status_q;
  assign out_o.possible    = out_possible_q;

`ifndef SYNTH
  // the amount still owed only ever shrinks while change is made
  a_amount_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUB) |=> (amount_q <= $past(amount_q)))
    else $error("remaining amount grew during make change");

  // loading the final result of a command frees the command port
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == S_IDLE))
    else $error("command not finished after its last result");

  // a result appears only when the sequencer loaded one
  a_valid_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(out_load))
    else $error("result valid without a load");
`endif

endmodule
